/* hw/rtl/bpw_pkg.sv */
package bpw_pkg;

    // framebuffer pixel layouts
    typedef enum logic [1:0] {
        FMT_565  = 2'd0,
        FMT_5551 = 2'd1,
        FMT_4444 = 2'd2,
        FMT_8888 = 2'd3
    } t_pix_fmt;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PIXEL_FORMAT = 2'd0;
    localparam t_cfg_idx CFG_FRAME_BASE   = 2'd1;
    localparam t_cfg_idx CFG_LINE_STRIDE  = 2'd2;

    localparam logic [1:0]  RST_PIXEL_FORMAT = 2'd3;
    localparam logic [31:0] RST_FRAME_BASE   = 32'd0;
    localparam logic [12:0] RST_LINE_STRIDE  = 13'd512;

    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // old pixel to bgr888, each field in the top bits of its byte
    function automatic logic [23:0] expand_old(input t_pix_fmt fmt, input logic [31:0] old);
        logic [15:0] h;
        logic [23:0] c;
        h = old[15:0];
        unique case (fmt)
            FMT_565:  c = {h[15:11], 3'b000, h[10:5], 2'b00, h[4:0], 3'b000};
            FMT_5551: c = {h[14:10], 3'b000, h[9:5], 3'b000, h[4:0], 3'b000};
            FMT_4444: c = {h[11:8], 4'b0000, h[7:4], 4'b0000, h[3:0], 4'b0000};
            FMT_8888: c = old[23:0];
            default:  c = old[23:0];
        endcase
        return c;
    endfunction

    // abgr8888 to framebuffer layout, 16-bit layouts zero-extended
    function automatic logic [31:0] pack(input t_pix_fmt fmt, input logic [31:0] c);
        logic [31:0] p;
        unique case (fmt)
            FMT_565:  p = {16'h0000, c[23:19], c[15:10], c[7:3]};
            FMT_5551: p = {16'h0000, 1'b0, c[23:19], c[15:11], c[7:3]};
            FMT_4444: p = {16'h0000, 4'h0, c[23:20], c[15:12], c[7:4]};
            FMT_8888: p = c;
            default:  p = c;
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/blended_pixel_writer_core.sv */
// blended pixel writer: takes one pixel word per clock (start high; busy is
// always low) and gives its framebuffer write word out of its last register
// stage, marked by o_strobe for one cycle. the receiver cannot stall the
// output, so every result must be taken in the cycle it is shown. the four
// register stages are input capture with clip test and old pixel expansion,
// the row multiply and channel products, the offset add and divide by 255,
// and the address add with packing. off-screen or fully transparent
// pixels still produce a word, with o_write_enable low and all other fields
// zero. configuration writes take effect at once and must only be made while
// no word is in flight.
module blended_pixel_writer_core #(
    parameter int SCREEN_W = 480,
    parameter int SCREEN_H = 272
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_pixel_x,
    input  logic [15:0] i_pixel_y,
    input  logic [31:0] i_src_color,
    input  logic [31:0] i_old_pixel,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_write_enable,
    output logic [31:0] o_byte_address,
    output logic [31:0] o_write_data,
    output logic        o_write_word
);

    localparam logic [16:0] W_LIM = 17'(SCREEN_W);
    localparam logic [16:0] H_LIM = 17'(SCREEN_H);

    // configuration registers
    bpw_pkg::t_pix_fmt r_pixel_format;
    logic [31:0]       r_frame_base;
    logic [12:0]       r_line_stride;

    // stage 1: captured word
    logic        r_s1_vld;
    logic        r_s1_hit;
    logic [15:0] r_s1_x;
    logic [15:0] r_s1_y;
    logic [31:0] r_s1_src;
    logic [23:0] r_s1_dst;
    // stage 2: row product
    logic        r_s2_vld;
    logic        r_s2_hit;
    logic [15:0] r_s2_x;
    logic [28:0] r_s2_prod;
    logic [31:0] r_s2_src;
    // stage 3: pixel offset, blended channels come out of the mixers here
    logic        r_s3_vld;
    logic        r_s3_hit;
    logic [29:0] r_s3_offset;
    logic [31:0] r_s3_src;
    // stage 4: output word
    logic        r_out_vld;
    logic        r_out_we;
    logic [31:0] r_out_addr;
    logic [31:0] r_out_data;
    logic        r_out_word;

    logic        in_fire;
    logic        in_hit;
    logic [7:0]  mix_ch [3];
    logic [31:0] s3_color;
    logic        s3_word;
    logic [31:0] s3_scaled;
    logic [31:0] n_out_addr;
    logic [31:0] n_out_data;

    assign busy    = 1'b0;
    assign in_fire = start && !busy;

    // clip test and transparency check on the raw input
    assign in_hit = ({1'b0, i_pixel_x} < W_LIM) && ({1'b0, i_pixel_y} < H_LIM)
                    && (i_src_color[31:24] != bpw_pkg::ALPHA_CLEAR);

    // configuration write port, writes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= bpw_pkg::t_pix_fmt'(bpw_pkg::RST_PIXEL_FORMAT);
            r_frame_base   <= bpw_pkg::RST_FRAME_BASE;
            r_line_stride  <= bpw_pkg::RST_LINE_STRIDE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpw_pkg::CFG_PIXEL_FORMAT: begin
                    r_pixel_format <= bpw_pkg::t_pix_fmt'(i_cfg_data[1:0]);
                end
                bpw_pkg::CFG_FRAME_BASE: begin
                    r_frame_base <= i_cfg_data;
                end
                bpw_pkg::CFG_LINE_STRIDE: begin
                    r_line_stride <= i_cfg_data[12:0];
                end
                default: begin
                end
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= in_fire;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // stage 1: capture, expand the old pixel to bgr888
    always_ff @(posedge i_clk) begin
        r_s1_hit <= in_hit;
        r_s1_x   <= i_pixel_x;
        r_s1_y   <= i_pixel_y;
        r_s1_src <= i_src_color;
        r_s1_dst <= bpw_pkg::expand_old(r_pixel_format, i_old_pixel);
    end

    // stage 2: row times stride
    always_ff @(posedge i_clk) begin
        r_s2_hit  <= r_s1_hit;
        r_s2_x    <= r_s1_x;
        r_s2_prod <= r_s1_y * r_line_stride;
        r_s2_src  <= r_s1_src;
    end

    // three channel mixers, red, green, blue
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        bpw_mix u_mix (
            .i_clk   (i_clk),
            .i_src   (r_s1_src[8*ch +: 8]),
            .i_dst   (r_s1_dst[8*ch +: 8]),
            .i_alpha (r_s1_src[31:24]),
            .o_mix   (mix_ch[ch])
        );
    end

    // stage 3: pixel offset within the frame
    always_ff @(posedge i_clk) begin
        r_s3_hit    <= r_s2_hit;
        r_s3_offset <= {14'd0, r_s2_x} + {1'b0, r_s2_prod};
        r_s3_src    <= r_s2_src;
    end

    // opaque source goes through untouched, blended alpha byte is zero
    assign s3_color = (r_s3_src[31:24] == bpw_pkg::ALPHA_OPAQUE)
                      ? r_s3_src
                      : {8'h00, mix_ch[2], mix_ch[1], mix_ch[0]};
    assign s3_word  = (r_pixel_format == bpw_pkg::FMT_8888);
    // byte offset fits 32 bits, the address add wraps modulo 2^32
    assign s3_scaled = s3_word ? {r_s3_offset, 2'b00} : {1'b0, r_s3_offset, 1'b0};
    assign n_out_addr = r_frame_base + s3_scaled;
    assign n_out_data = bpw_pkg::pack(r_pixel_format, s3_color);

    // stage 4: output word, fields cleared when nothing is written
    always_ff @(posedge i_clk) begin
        r_out_we   <= r_s3_hit;
        r_out_addr <= r_s3_hit ? n_out_addr : 32'd0;
        r_out_data <= r_s3_hit ? n_out_data : 32'd0;
        r_out_word <= r_s3_hit && s3_word;
    end

    assign o_strobe       = r_out_vld;
    assign o_write_enable = r_out_vld && r_out_we;
    assign o_byte_address = r_out_addr;
    assign o_write_data   = r_out_data;
    assign o_write_word   = r_out_word;

`ifndef NO_ASSERTIONS
    // every accepted word reaches the output after the four register stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> ##4 o_strobe)
        else $error("accepted word did not reach the output");

    // no output word without an accepted word ahead of it in the pipeline
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(in_fire, 4))
        else $error("output word without an input word");

    // a skipped write carries all-zero fields
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_write_enable) |->
            (o_byte_address == 32'd0 && o_write_data == 32'd0 && !o_write_word))
        else $error("skipped write has nonzero fields");

    // write size follows the configured layout
    a_word_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> (o_write_word == (r_pixel_format == bpw_pkg::FMT_8888)))
        else $error("write size does not match pixel format");
`endif

endmodule

/* hw/rtl/bpw_mix.sv */
// one color channel: floor((s*a + d*(255-a)) / 255)
module bpw_mix (
    input  logic       i_clk,
    input  logic [7:0] i_src,
    input  logic [7:0] i_dst,
    input  logic [7:0] i_alpha,
    output logic [7:0] o_mix
);

    logic [15:0] r_prod_s;
    logic [15:0] r_prod_d;
    logic [7:0]  r_mix;
    logic [15:0] sum;
    logic [15:0] adj;

    always_ff @(posedge i_clk) begin
        r_prod_s <= i_src * i_alpha;
        r_prod_d <= i_dst * (8'hff - i_alpha);
    end

    // sum never exceeds 255*255, so the add cannot carry out
    assign sum = r_prod_s + r_prod_d;
    // exact floor(v/255) for v up to 255*255, peak 65280 fits 16 bits
    assign adj = sum + 16'd1 + {8'd0, sum[15:8]};

    always_ff @(posedge i_clk) begin
        r_mix <= adj[15:8];
    end

    assign o_mix = r_mix;

endmodule
